// ===== rtl/core/mvh_pkg.sv =====
// Shared constants, register codes and arctangent table for the magnetometer heading unit.
`timescale 1ns / 1ps

package mvh_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int MAG_W      = 34;
    localparam int WIN_W      = 33;
    localparam int HEAD_W     = 16;
    localparam int COUNT_W    = 32;
    localparam int Z_W        = 32;
    localparam int ATAN_IDX_W = 5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = WIN_W;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_OFFSET_X    = 3'd0;
    localparam t_cfg_idx CFG_OFFSET_Y    = 3'd1;
    localparam t_cfg_idx CFG_WIN_LOW_SQ  = 3'd2;
    localparam t_cfg_idx CFG_WIN_HIGH_SQ = 3'd3;
    localparam t_cfg_idx CFG_ROT_COS     = 3'd4;
    localparam t_cfg_idx CFG_ROT_SIN     = 3'd5;
    localparam t_cfg_idx CFG_Y_GAIN      = 3'd6;
    localparam t_cfg_idx CFG_CHECK_ON    = 3'd7;

    localparam logic [WIN_W-1:0] WIN_HIGH_RESET = 33'd8589672450;
    localparam logic [SAMPLE_W-1:0] UNITY_Q14   = 16'd16384;

    // quarter turn in units of 2^-16 centidegree
    localparam logic signed [Z_W-1:0] QUARTER_UNITS = 32'sd589824000;
    localparam logic signed [Z_W-1:0] ROUND_HALF    = 32'sd32768;

    localparam logic [HEAD_W:0] HALF_TURN_CDEG = 17'd18000;
    localparam logic [HEAD_W:0] FULL_TURN_CDEG = 17'd36000;

    typedef struct packed {
        logic x_neg;
        logic y_neg;
    } t_quadrant;

    function automatic logic signed [Z_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 32'sd294912000;
            5'd1:    v = 32'sd174096719;
            5'd2:    v = 32'sd91987925;
            5'd3:    v = 32'sd46694507;
            5'd4:    v = 32'sd23437865;
            5'd5:    v = 32'sd11730358;
            5'd6:    v = 32'sd5866610;
            5'd7:    v = 32'sd2933484;
            5'd8:    v = 32'sd1466764;
            5'd9:    v = 32'sd733385;
            5'd10:   v = 32'sd366693;
            5'd11:   v = 32'sd183346;
            5'd12:   v = 32'sd91673;
            5'd13:   v = 32'sd45837;
            5'd14:   v = 32'sd22918;
            5'd15:   v = 32'sd11459;
            5'd16:   v = 32'sd5730;
            5'd17:   v = 32'sd2865;
            5'd18:   v = 32'sd1432;
            5'd19:   v = 32'sd716;
            5'd20:   v = 32'sd358;
            5'd21:   v = 32'sd179;
            5'd22:   v = 32'sd90;
            5'd23:   v = 32'sd45;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/mvh_cordic.sv =====
// Iterative vectoring CORDIC that turns a corrected field vector into a heading.
`timescale 1ns / 1ps

module mvh_cordic #(
    parameter int CORDIC_STEPS = 16,
    parameter int VEC_W        = 55
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [VEC_W-1:0]           i_x,
    input  logic signed [VEC_W-1:0]           i_y,
    output logic                              o_done,
    output logic [mvh_pkg::HEAD_W-1:0]        o_heading
);
    import mvh_pkg::*;

    localparam int SW = $clog2(CORDIC_STEPS);
    localparam logic [SW-1:0] LAST_STEP = SW'(CORDIC_STEPS - 1);

    typedef enum logic [1:0] {
        C_IDLE,
        C_RUN,
        C_FIN
    } t_cstate;

    t_cstate r_state;
    t_cstate n_state;

    logic signed [VEC_W-1:0] r_x;
    logic signed [VEC_W-1:0] r_y;
    logic signed [Z_W-1:0]   r_z;
    logic [SW-1:0]           r_cnt;
    t_quadrant               r_quad;
    logic                    r_done;
    logic [HEAD_W-1:0]       r_heading;

    logic signed [VEC_W-1:0] x_sh;
    logic signed [VEC_W-1:0] y_sh;
    logic signed [Z_W-1:0]   step_angle;
    logic signed [Z_W-1:0]   z_clamped;
    logic signed [Z_W-1:0]   z_rounded;
    logic [HEAD_W-3:0]       angle_cdeg;
    logic [HEAD_W:0]         head_raw;
    logic [HEAD_W:0]         head_wrapped;
    logic                    vec_zero;

    assign vec_zero   = (i_x == '0) && (i_y == '0);
    assign x_sh       = r_x >>> r_cnt;
    assign y_sh       = r_y >>> r_cnt;
    assign step_angle = atan_entry(ATAN_IDX_W'(r_cnt));

    always_comb begin
        if (r_z[Z_W-1]) begin
            z_clamped = '0;
        end else if (r_z > QUARTER_UNITS) begin
            z_clamped = QUARTER_UNITS;
        end else begin
            z_clamped = r_z;
        end
        z_rounded  = z_clamped + ROUND_HALF;
        angle_cdeg = z_rounded[29:16];
        if (!r_quad.x_neg && !r_quad.y_neg) begin
            head_raw = {3'b000, angle_cdeg};
        end else if (r_quad.x_neg && !r_quad.y_neg) begin
            head_raw = HALF_TURN_CDEG - {3'b000, angle_cdeg};
        end else if (r_quad.x_neg) begin
            head_raw = HALF_TURN_CDEG + {3'b000, angle_cdeg};
        end else begin
            head_raw = FULL_TURN_CDEG - {3'b000, angle_cdeg};
        end
        if (head_raw >= FULL_TURN_CDEG) begin
            head_wrapped = head_raw - FULL_TURN_CDEG;
        end else begin
            head_wrapped = head_raw;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE: begin
                if (i_start && !vec_zero) begin
                    n_state = C_RUN;
                end
            end
            C_RUN: begin
                if (r_cnt == LAST_STEP) begin
                    n_state = C_FIN;
                end
            end
            C_FIN: begin
                n_state = C_IDLE;
            end
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= C_IDLE;
            r_done    <= 1'b0;
            r_heading <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_start && vec_zero) begin
                        r_heading <= '0;
                        r_done    <= 1'b1;
                    end
                end
                C_FIN: begin
                    r_heading <= head_wrapped[HEAD_W-1:0];
                    r_done    <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    r_x          <= i_x[VEC_W-1] ? -i_x : i_x;
                    r_y          <= i_y[VEC_W-1] ? -i_y : i_y;
                    r_z          <= '0;
                    r_cnt        <= '0;
                    r_quad.x_neg <= i_x[VEC_W-1];
                    r_quad.y_neg <= i_y[VEC_W-1];
                end
            end
            C_RUN: begin
                if (!r_y[VEC_W-1]) begin
                    r_x <= r_x + y_sh;
                    r_y <= r_y - x_sh;
                    r_z <= r_z + step_angle;
                end else begin
                    r_x <= r_x - y_sh;
                    r_y <= r_y + x_sh;
                    r_z <= r_z - step_angle;
                end
                r_cnt <= r_cnt + 1'b1;
            end
            default: ;
        endcase
    end

    assign o_done    = r_done;
    assign o_heading = r_heading;

endmodule

// ===== rtl/core/magnetometer_validate_heading_unit.sv =====
// Top level: magnetometer sample validation, soft-iron correction and compass heading.
//
// Input channel: i_in_valid / o_in_stall carry one raw x, y, z sample per item.
// Output channel: o_out_valid / i_out_stall carry the accepted or held sample, the
// heading in 0.01 degree steps, the reject flag and the running reject count.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index; write only
// while no item is in flight.
// Each item makes seven passes through the one shared 35x17 multiplier
// (magnitude, then rotation and y gain after the window decision) and then
// runs the iterative CORDIC, whose iterations are skipped when the corrected
// vector is zero.
// o_in_stall is high while an item is in work; a finished item sits in the
// output register, and a new item is taken meanwhile. A stalled result holds
// and the next one waits inside the block until the output register frees.
// Reset: synchronous active low; clears the held sample, the valid flag and the
// reject count and restores all configuration registers to their defaults.
`timescale 1ns / 1ps

module magnetometer_validate_heading_unit #(
    parameter int CORDIC_STEPS   = 16,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [mvh_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [mvh_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [mvh_pkg::SAMPLE_W-1:0]    i_raw_x,
    input  logic signed [mvh_pkg::SAMPLE_W-1:0]    i_raw_y,
    input  logic signed [mvh_pkg::SAMPLE_W-1:0]    i_raw_z,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [mvh_pkg::SAMPLE_W-1:0]    o_field_x,
    output logic signed [mvh_pkg::SAMPLE_W-1:0]    o_field_y,
    output logic signed [mvh_pkg::SAMPLE_W-1:0]    o_field_z,
    output logic [mvh_pkg::HEAD_W-1:0]             o_heading_cdeg,
    output logic                                   o_was_rejected,
    output logic [mvh_pkg::COUNT_W-1:0]            o_reject_total
);
    import mvh_pkg::*;

    localparam int MA_W   = MAG_W + 1;
    localparam int MB_W   = DIFF_W;
    localparam int PROD_W = MA_W + MB_W;
    localparam int XR_W   = MAG_W;
    localparam int XS_W   = XR_W + COEF_FRAC_BITS;
    localparam int VEC_W  = ((XS_W > PROD_W) ? XS_W : PROD_W) + 3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAG0,
        S_MAG1,
        S_DECIDE,
        S_XR0,
        S_XR1,
        S_YR0,
        S_YR1,
        S_YG,
        S_CSTART,
        S_CWAIT,
        S_HOLD
    } t_state;

    t_state r_state;
    t_state n_state;

    logic signed [SAMPLE_W-1:0] r_off_x;
    logic signed [SAMPLE_W-1:0] r_off_y;
    logic [WIN_W-1:0]           r_win_lo;
    logic [WIN_W-1:0]           r_win_hi;
    logic signed [SAMPLE_W-1:0] r_cos;
    logic signed [SAMPLE_W-1:0] r_sin;
    logic [SAMPLE_W-1:0]        r_gain;
    logic                       r_check;

    logic [SAMPLE_W-1:0]        r_held_x;
    logic [SAMPLE_W-1:0]        r_held_y;
    logic [SAMPLE_W-1:0]        r_held_z;
    logic                       r_have;
    logic [COUNT_W-1:0]         r_rcount;

    logic [SAMPLE_W-1:0]        r_rx;
    logic [SAMPLE_W-1:0]        r_ry;
    logic [SAMPLE_W-1:0]        r_rz;
    logic [SAMPLE_W-1:0]        r_fx;
    logic [SAMPLE_W-1:0]        r_fy;
    logic [SAMPLE_W-1:0]        r_fz;
    logic                       r_rej;
    logic signed [DIFF_W-1:0]   r_dx;
    logic signed [DIFF_W-1:0]   r_dy;
    logic signed [PROD_W-1:0]   r_acc;
    logic [MAG_W-1:0]           r_m2;
    logic signed [XR_W-1:0]     r_xr;

    logic                       r_out_valid;
    logic [SAMPLE_W-1:0]        r_out_x;
    logic [SAMPLE_W-1:0]        r_out_y;
    logic [SAMPLE_W-1:0]        r_out_z;
    logic [HEAD_W-1:0]          r_out_head;
    logic                       r_out_rej;
    logic [COUNT_W-1:0]         r_out_count;

    logic                       in_accept;
    logic                       out_free;
    logic                       out_load;
    logic                       in_window;
    logic                       use_held;
    logic [SAMPLE_W-1:0]        sel_x;
    logic [SAMPLE_W-1:0]        sel_y;
    logic [SAMPLE_W-1:0]        sel_z;
    logic signed [MA_W-1:0]     mul_a;
    logic signed [MB_W-1:0]     mul_b;
    logic signed [PROD_W-1:0]   prod;
    logic signed [VEC_W-1:0]    vec_x;
    logic signed [VEC_W-1:0]    vec_y;
    logic                       cordic_start;
    logic                       cordic_done;
    logic [HEAD_W-1:0]          cordic_heading;

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign out_load  = ((r_state == S_CWAIT) && cordic_done && out_free)
                     || ((r_state == S_HOLD) && out_free);

    assign in_window = (r_m2 > {1'b0, r_win_lo}) && (r_m2 < {1'b0, r_win_hi});
    assign use_held  = r_check && !in_window && r_have;
    assign sel_x     = use_held ? r_held_x : r_rx;
    assign sel_y     = use_held ? r_held_y : r_ry;
    assign sel_z     = use_held ? r_held_z : r_rz;

    always_comb begin
        unique case (r_state)
            S_MAG0: begin
                mul_a = MA_W'(r_dx);
                mul_b = r_dx;
            end
            S_MAG1: begin
                mul_a = MA_W'(r_dy);
                mul_b = r_dy;
            end
            S_XR0: begin
                mul_a = MA_W'(r_dx);
                mul_b = MB_W'(r_cos);
            end
            S_XR1: begin
                mul_a = MA_W'(r_dy);
                mul_b = MB_W'(r_sin);
            end
            S_YR0: begin
                mul_a = MA_W'(r_dy);
                mul_b = MB_W'(r_cos);
            end
            S_YR1: begin
                mul_a = MA_W'(r_dx);
                mul_b = MB_W'(r_sin);
            end
            S_YG: begin
                mul_a = r_acc[MA_W-1:0];
                mul_b = $signed({1'b0, r_gain});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    assign vec_x = $signed({{(VEC_W - XS_W){r_xr[XR_W-1]}}, r_xr, {COEF_FRAC_BITS{1'b0}}});
    assign vec_y = $signed({{(VEC_W - PROD_W){r_acc[PROD_W-1]}}, r_acc});
    assign cordic_start = (r_state == S_CSTART);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) begin
                n_state = S_MAG0;
            end
            S_MAG0:   n_state = S_MAG1;
            S_MAG1:   n_state = S_DECIDE;
            S_DECIDE: n_state = S_XR0;
            S_XR0:    n_state = S_XR1;
            S_XR1:    n_state = S_YR0;
            S_YR0:    n_state = S_YR1;
            S_YR1:    n_state = S_YG;
            S_YG:     n_state = S_CSTART;
            S_CSTART: n_state = S_CWAIT;
            S_CWAIT: begin
                if (cordic_done) begin
                    n_state = out_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD:   if (out_free) begin
                n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_off_x     <= '0;
            r_off_y     <= '0;
            r_win_lo    <= '0;
            r_win_hi    <= WIN_HIGH_RESET;
            r_cos       <= UNITY_Q14;
            r_sin       <= '0;
            r_gain      <= UNITY_Q14;
            r_check     <= 1'b1;
            r_held_x    <= '0;
            r_held_y    <= '0;
            r_held_z    <= '0;
            r_have      <= 1'b0;
            r_rcount    <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_OFFSET_X:    r_off_x  <= i_cfg_data[SAMPLE_W-1:0];
                    CFG_OFFSET_Y:    r_off_y  <= i_cfg_data[SAMPLE_W-1:0];
                    CFG_WIN_LOW_SQ:  r_win_lo <= i_cfg_data[WIN_W-1:0];
                    CFG_WIN_HIGH_SQ: r_win_hi <= i_cfg_data[WIN_W-1:0];
                    CFG_ROT_COS:     r_cos    <= i_cfg_data[SAMPLE_W-1:0];
                    CFG_ROT_SIN:     r_sin    <= i_cfg_data[SAMPLE_W-1:0];
                    CFG_Y_GAIN:      r_gain   <= i_cfg_data[SAMPLE_W-1:0];
                    CFG_CHECK_ON:    r_check  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_state == S_DECIDE && r_check) begin
                if (in_window) begin
                    r_held_x <= r_rx;
                    r_held_y <= r_ry;
                    r_held_z <= r_rz;
                    r_have   <= 1'b1;
                end else if (r_have) begin
                    r_rcount <= r_rcount + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rx <= i_raw_x;
            r_ry <= i_raw_y;
            r_rz <= i_raw_z;
            r_dx <= DIFF_W'(i_raw_x) - DIFF_W'(r_off_x);
            r_dy <= DIFF_W'(i_raw_y) - DIFF_W'(r_off_y);
        end
        unique case (r_state)
            S_MAG0: r_acc <= prod;
            S_MAG1: r_m2  <= r_acc[MAG_W-1:0] + prod[MAG_W-1:0];
            S_DECIDE: begin
                r_fx  <= sel_x;
                r_fy  <= sel_y;
                r_fz  <= sel_z;
                r_rej <= use_held;
                r_dx  <= DIFF_W'($signed(sel_x)) - DIFF_W'(r_off_x);
                r_dy  <= DIFF_W'($signed(sel_y)) - DIFF_W'(r_off_y);
            end
            S_XR0:  r_acc <= prod;
            S_XR1:  r_xr  <= XR_W'(r_acc + prod);
            S_YR0:  r_acc <= prod;
            S_YR1:  r_acc <= r_acc - prod;
            S_YG:   r_acc <= prod;
            default: ;
        endcase
        if (out_load) begin
            r_out_x     <= r_fx;
            r_out_y     <= r_fy;
            r_out_z     <= r_fz;
            r_out_head  <= cordic_heading;
            r_out_rej   <= r_rej;
            r_out_count <= r_rcount;
        end
    end

    mvh_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .VEC_W        (VEC_W)
    ) u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (cordic_start),
        .i_x       (vec_x),
        .i_y       (vec_y),
        .o_done    (cordic_done),
        .o_heading (cordic_heading)
    );

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_field_x      = r_out_x;
    assign o_field_y      = r_out_y;
    assign o_field_z      = r_out_z;
    assign o_heading_cdeg = r_out_head;
    assign o_was_rejected = r_out_rej;
    assign o_reject_total = r_out_count;

endmodule
